/* rtl/udiv_pkg.sv */
package udiv_pkg;

   // Width of every payload field at the ports.
   localparam int FIELD_W = 32;

   // Default width of the internal datapath.
   localparam int DEFAULT_WIDTH = 32;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // Strobes from the sequencer to the datapath.
   typedef struct packed {
      logic idle;    // Ready for a new request.
      logic load;    // Capture the operands of an accepted request.
      logic step;    // Run one shift-subtract iteration.
      logic finish;  // Move the result into the output register.
   } ctrl_type;

endpackage

/* rtl/unsigned_iterative_divider_core.sv */
// A request runs one shift-subtract iteration per quotient bit in ST_RUN, then waits in ST_FINISH
// until the output register is free; a zero divisor skips the iterations and goes to ST_FINISH.
// No new request is taken until the sequencer is back in ST_IDLE; the single shift-subtract
// unit produces one quotient bit per cycle.
// Reset is synchronous and active high; it clears the sequencer and the output valid.
module unsigned_iterative_divider_core
   import udiv_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [FIELD_W-1:0] req_dividend,
   input  logic [FIELD_W-1:0] req_divisor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_quotient,
   output logic [FIELD_W-1:0] rsp_remainder,
   output logic               rsp_div_by_zero
);

   localparam int EXT_W = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

   ctrl_type           ctrl;
   logic [EXT_W-1:0]   dividend_ext;
   logic [EXT_W-1:0]   divisor_ext;
   logic [WIDTH-1:0]   dividend_w;
   logic [WIDTH-1:0]   divisor_w;
   logic               divisor_zero;
   logic               out_free;

   logic [WIDTH-1:0]   rem_ff;
   logic [WIDTH-1:0]   rem_in;
   logic [WIDTH-1:0]   quo_ff;
   logic [WIDTH-1:0]   quo_in;
   logic [WIDTH-1:0]   div_ff;
   logic [WIDTH-1:0]   div_in;
   logic               zero_ff;
   logic               zero_in;
   logic [WIDTH-1:0]   rem_step;
   logic [WIDTH-1:0]   quo_step;
   logic [EXT_W-1:0]   quo_ext;
   logic [EXT_W-1:0]   rem_ext;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [FIELD_W-1:0] rsp_quo_ff;
   logic [FIELD_W-1:0] rsp_rem_ff;
   logic               rsp_zero_ff;

   // Operands at the datapath width; bits above WIDTH are dropped.
   assign dividend_ext = EXT_W'(req_dividend);
   assign divisor_ext  = EXT_W'(req_divisor);
   assign dividend_w   = dividend_ext[WIDTH-1:0];
   assign divisor_w    = divisor_ext[WIDTH-1:0];
   assign divisor_zero = (divisor_w == '0);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctrl.idle;

   udiv_ctrl #(
      .WIDTH (WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .divisor_zero (divisor_zero),
      .out_free     (out_free),
      .ctrl         (ctrl)
   );

   udiv_step #(
      .WIDTH (WIDTH)
   ) u_step (
      .rem_cur  (rem_ff),
      .quo_cur  (quo_ff),
      .divisor  (div_ff),
      .rem_next (rem_step),
      .quo_next (quo_step)
   );

   // Working registers: the dividend shifts out of quo_ff as quotient bits shift in.
   // A zero divisor loads zeros so the finish step passes them straight through.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      zero_in = zero_ff;
      if (ctrl.load) begin
         rem_in  = '0;
         quo_in  = divisor_zero ? '0 : dividend_w;
         div_in  = divisor_w;
         zero_in = divisor_zero;
      end else if (ctrl.step) begin
         rem_in = rem_step;
         quo_in = quo_step;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      zero_ff <= zero_in;
   end

   // Output register, loaded once the previous result has been taken.
   assign quo_ext = EXT_W'(quo_ff);
   assign rem_ext = EXT_W'(rem_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_quo_ff  <= quo_ext[FIELD_W-1:0];
         rsp_rem_ff  <= rem_ext[FIELD_W-1:0];
         rsp_zero_ff <= zero_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quotient    = rsp_quo_ff;
   assign rsp_remainder   = rsp_rem_ff;
   assign rsp_div_by_zero = rsp_zero_ff;

endmodule

/* rtl/udiv_step.sv */
module udiv_step
   import udiv_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic [WIDTH-1:0] rem_cur,
   input  logic [WIDTH-1:0] quo_cur,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] rem_next,
   output logic [WIDTH-1:0] quo_next
);

   logic [WIDTH:0] trial;
   logic [WIDTH:0] diff;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   always_comb begin
      trial = {rem_cur, quo_cur[WIDTH-1]};
      diff  = trial - {1'b0, divisor};
      if (!diff[WIDTH]) begin
         rem_next = diff[WIDTH-1:0];
         quo_next = {quo_cur[WIDTH-2:0], 1'b1};
      end else begin
         rem_next = trial[WIDTH-1:0];
         quo_next = {quo_cur[WIDTH-2:0], 1'b0};
      end
   end

endmodule

/* rtl/udiv_ctrl.sv */
module udiv_ctrl
   import udiv_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     divisor_zero,
   input  logic     out_free,
   output ctrl_type ctrl
);

   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = divisor_zero ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Strobes for the datapath.
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.idle = 1'b1;
            ctrl.load = req_valid;
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
         end
         ST_FINISH: begin
            ctrl.finish = out_free;
         end
         default: ctrl = '0;
      endcase
   end

   // Iteration counter, one count per quotient bit.
   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         cnt_in = '0;
      end else if (ctrl.step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/udiv_checker.sv */
module udiv_checker
   import udiv_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FIELD_W-1:0] rsp_quotient,
   input logic [FIELD_W-1:0] rsp_remainder,
   input logic               rsp_div_by_zero
);

   // A request transfer starts work, so the block cannot take another next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("divider ready right after a request transfer");

   // A divide by zero reports zero quotient and remainder.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_quotient == '0 && rsp_remainder == '0)
      else $error("divide by zero with nonzero result fields");

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient)
         && $stable(rsp_remainder) && $stable(rsp_div_by_zero))
      else $error("result changed while stalled");

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind unsigned_iterative_divider_core udiv_checker u_udiv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_quotient    (rsp_quotient),
   .rsp_remainder   (rsp_remainder),
   .rsp_div_by_zero (rsp_div_by_zero)
);
